### hw/rtl/ssus_pkg.sv
// Package for the sorted unique set store: command and status codes, cell control.
// No dependencies. Every other file in hw/rtl uses it.
package ssus_pkg;

  localparam int KEY_W      = 32;
  localparam int COUNT_W    = 6;
  localparam int READ_LIMIT = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } fsm_e;

  typedef struct packed {
    cell_op_e          op;
    logic [KEY_W-1:0]  key;
  } cell_ctl_t;

endpackage

### hw/rtl/ssus_if.sv
// Valid/ready channel interfaces for command words and result words.
// Depends on ssus_pkg for field widths.
interface ssus_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          opcode;
  logic signed [ssus_pkg::KEY_W-1:0]   key;
  logic [ssus_pkg::COUNT_W-1:0]        count;

  modport source (output valid, output opcode, output key, output count, input ready);
  modport sink   (input valid, input opcode, input key, input count, output ready);
endinterface

interface ssus_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic signed [ssus_pkg::KEY_W-1:0]   entry_value;
  logic                                is_last;

  modport source (output valid, output status, output entry_value, output is_last,
                  input ready);
  modport sink   (input valid, input status, input entry_value, input is_last,
                  output ready);
endinterface

### hw/rtl/ssus_cell.sv
// One compare-and-shift cell of the set chain: holds one entry.
// Depends on ssus_pkg for the cell control struct.
module ssus_cell (
  input  logic                              clk_i,
  input  ssus_pkg::cell_ctl_t               ctl_i,
  input  logic                              valid_i,
  input  logic [ssus_pkg::KEY_W-1:0]        left_val_i,
  input  logic                              left_gt_i,
  input  logic [ssus_pkg::KEY_W-1:0]        right_val_i,
  output logic [ssus_pkg::KEY_W-1:0]        val_o,
  output logic                              gt_o,
  output logic                              eq_o
);

  logic [ssus_pkg::KEY_W-1:0] val_q, val_d;

  assign gt_o  = valid_i && ($signed(val_q) > $signed(ctl_i.key));
  assign eq_o  = valid_i && (val_q == ctl_i.key);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    case (ctl_i.op)
      ssus_pkg::CELL_INSERT: begin
        if (!gt_o) begin
          val_d = left_gt_i ? ctl_i.key : left_val_i;
        end
      end
      ssus_pkg::CELL_REMOVE: begin
        if (!gt_o) begin
          val_d = right_val_i;
        end
      end
      ssus_pkg::CELL_ROTATE: val_d = right_val_i;
      default:               val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

### hw/rtl/sorted_unique_set_store_core.sv
// Top level of the sorted unique set store: a chain of compare-and-shift cells,
// occupancy count, read sequencer and result register. Uses ssus_pkg, ssus_if, ssus_cell.
//
//  port    dir  word                           handshake
//  in_i    in   opcode, key, count             valid/ready
//  out_o   out  status, entry_value, is_last   valid/ready
//
// Insert, remove and clear update the chain and the result register as they are taken;
// a new command word is taken every cycle while the result register drains.
// A read of at least one entry rotates the whole chain once, stalling on output back-pressure
// while entries remain, emitting the leading entries from cell 0 on the way. No command is taken meanwhile.
// Reset clears occupancy, the sequencer and result valid; cell contents are not reset.
module sorted_unique_set_store_core #(
  parameter int CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssus_in_if.sink     in_i,
  ssus_out_if.source  out_o
);

  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int N_W   = (OCC_W > ssus_pkg::COUNT_W) ? OCC_W : ssus_pkg::COUNT_W;

  logic [ssus_pkg::KEY_W-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0]        gt_vec, eq_vec, valid_vec;
  ssus_pkg::cell_ctl_t        ctl;

  ssus_pkg::fsm_e             state_q, state_d;
  logic [OCC_W-1:0]           occ_q, occ_d, n_q, n_d;
  logic [IDX_W-1:0]           rot_q, rot_d;

  logic                       out_valid_q;
  logic [1:0]                 status_q, status_d;
  logic [ssus_pkg::KEY_W-1:0] value_q, value_d;
  logic                       last_q, last_d;
  logic                       ld;

  logic                       slot_free, accept, hit, full, step;
  logic [N_W-1:0]             cnt_ext, occ_ext, n_calc;

  // cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign valid_vec[g] = OCC_W'(g) < occ_q;
    ssus_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (valid_vec[g]),
      .left_val_i  ((g == 0) ? vals[0] : vals[(g == 0) ? 0 : g - 1]),
      .left_gt_i   ((g == 0) ? 1'b1 : gt_vec[(g == 0) ? 0 : g - 1]),
      .right_val_i ((g == CAPACITY - 1) ? vals[0] : vals[(g == CAPACITY - 1) ? 0 : g + 1]),
      .val_o       (vals[g]),
      .gt_o        (gt_vec[g]),
      .eq_o        (eq_vec[g])
    );
  end

  assign hit       = |eq_vec;
  assign full      = occ_q == OCC_W'(CAPACITY);
  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ssus_pkg::S_IDLE) && slot_free;
  assign accept    = in_i.valid && in_i.ready;

  always_comb begin
    cnt_ext = N_W'(in_i.count);
    occ_ext = N_W'(occ_q);
    n_calc  = (cnt_ext < occ_ext) ? cnt_ext : occ_ext;
    if (n_calc > N_W'(ssus_pkg::READ_LIMIT)) begin
      n_calc = N_W'(ssus_pkg::READ_LIMIT);
    end
  end

  assign step = (OCC_W'(rot_q) >= n_q) || slot_free;

  always_comb begin
    state_d  = state_q;
    occ_d    = occ_q;
    n_d      = n_q;
    rot_d    = rot_q;
    ctl.op   = ssus_pkg::CELL_HOLD;
    ctl.key  = in_i.key;
    ld       = 1'b0;
    status_d = ssus_pkg::ST_DONE;
    value_d  = '0;
    last_d   = 1'b1;
    unique case (state_q)
      ssus_pkg::S_IDLE: begin
        if (accept) begin
          unique case (ssus_pkg::op_e'(in_i.opcode))
            ssus_pkg::OP_INSERT: begin
              ld = 1'b1;
              if (hit) begin
                status_d = ssus_pkg::ST_MISS;
              end else if (full) begin
                status_d = ssus_pkg::ST_FULL;
              end else begin
                ctl.op = ssus_pkg::CELL_INSERT;
                occ_d  = occ_q + 1'b1;
              end
            end
            ssus_pkg::OP_REMOVE: begin
              ld = 1'b1;
              if (hit) begin
                ctl.op = ssus_pkg::CELL_REMOVE;
                occ_d  = occ_q - 1'b1;
              end else begin
                status_d = ssus_pkg::ST_MISS;
              end
            end
            ssus_pkg::OP_CLEAR: begin
              ld    = 1'b1;
              occ_d = '0;
            end
            ssus_pkg::OP_READ: begin
              if (n_calc == '0) begin
                ld       = 1'b1;
                status_d = ssus_pkg::ST_EMPTY;
              end else begin
                state_d = ssus_pkg::S_READ;
                n_d     = OCC_W'(n_calc);
                rot_d   = '0;
              end
            end
            default: ld = 1'b0;
          endcase
        end
      end
      ssus_pkg::S_READ: begin
        if (step) begin
          ctl.op = ssus_pkg::CELL_ROTATE;
          if (OCC_W'(rot_q) < n_q) begin
            ld      = 1'b1;
            value_d = vals[0];
            last_d  = (OCC_W'(rot_q) + 1'b1) == n_q;
          end
          if (rot_q == IDX_W'(CAPACITY - 1)) begin
            state_d = ssus_pkg::S_IDLE;
            rot_d   = '0;
          end else begin
            rot_d = rot_q + 1'b1;
          end
        end
      end
      default: state_d = ssus_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssus_pkg::S_IDLE;
      occ_q       <= '0;
      n_q         <= '0;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      n_q     <= n_d;
      rot_q   <= rot_d;
      if (ld) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      status_q <= status_d;
      value_q  <= value_d;
      last_q   <= last_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.entry_value = value_q;
  assign out_o.is_last     = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.valid && in_i.ready) |=> $stable(occ_q))
    else $error("occupancy changed without a command word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssus_pkg::S_READ) |=> (occ_q == $past(occ_q)))
    else $error("occupancy changed during read rotation");

  for (genvar a = 0; a + 1 < CAPACITY; a++) begin : g_order_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ssus_pkg::S_IDLE) && valid_vec[a + 1]
        |-> ($signed(vals[a]) > $signed(vals[a + 1])))
      else $error("chain not strictly descending");
  end

endmodule

### test/tb_sorted_unique_set_store_core.sv
// Testbench for sorted_unique_set_store_core: directed and random command words,
// checked against an in-bench model of the descending set. Uses ssus_pkg, ssus_if.
`timescale 1ns / 1ps

module tb_sorted_unique_set_store_core;

  localparam int CAP         = 32;
  localparam int POOL_N      = 48;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 1000000;

  typedef struct {
    ssus_pkg::op_e                     op;
    logic signed [ssus_pkg::KEY_W-1:0] key;
    logic [ssus_pkg::COUNT_W-1:0]      count;
  } cmd_t;

  typedef struct {
    ssus_pkg::status_e                 status;
    logic signed [ssus_pkg::KEY_W-1:0] value;
    logic                              last;
  } result_t;

  logic clk;
  logic rst_n;

  ssus_in_if  in_if ();
  ssus_out_if out_if ();

  sorted_unique_set_store_core #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  cmd_t    cmd_q[$];
  result_t predicted_q[$];

  logic signed [ssus_pkg::KEY_W-1:0] set_val [CAP];
  int                                set_size;
  logic signed [ssus_pkg::KEY_W-1:0] key_pool [POOL_N];

  bit calm;
  bit cmd_taken;
  bit res_taken;
  bit hold_req;
  bit hold_ack;
  int hold_left;
  int send_wait;
  int recv_wait;
  int errors;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // set model: one command word in, its result words out
  task automatic apply_command(input ssus_pkg::op_e op,
                               input logic signed [ssus_pkg::KEY_W-1:0] key,
                               input logic [ssus_pkg::COUNT_W-1:0] count);
    int      pos;
    int      n;
    result_t r;
    pos = 0;
    r.status = ssus_pkg::ST_DONE;
    r.value  = '0;
    r.last   = 1'b1;
    case (op)
      ssus_pkg::OP_CLEAR: begin
        set_size = 0;
        predicted_q.push_back(r);
      end
      ssus_pkg::OP_READ: begin
        n = (int'(count) < set_size) ? int'(count) : set_size;
        if (n > ssus_pkg::READ_LIMIT) n = ssus_pkg::READ_LIMIT;
        if (n == 0) begin
          r.status = ssus_pkg::ST_EMPTY;
          predicted_q.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.value = set_val[i];
            r.last  = (i == n - 1);
            predicted_q.push_back(r);
          end
        end
      end
      default: begin
        while (pos < set_size && set_val[pos] > key) pos++;
        if (op == ssus_pkg::OP_INSERT) begin
          if (pos < set_size && set_val[pos] == key) begin
            r.status = ssus_pkg::ST_MISS;
          end else if (set_size >= CAP) begin
            r.status = ssus_pkg::ST_FULL;
          end else begin
            for (int i = set_size; i > pos; i--) set_val[i] = set_val[i-1];
            set_val[pos] = key;
            set_size++;
          end
        end else begin
          if (pos >= set_size || set_val[pos] != key) begin
            r.status = ssus_pkg::ST_MISS;
          end else begin
            for (int i = pos; i + 1 < set_size; i++) set_val[i] = set_val[i+1];
            set_size--;
          end
        end
        predicted_q.push_back(r);
      end
    endcase
  endtask

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    result_t want;
    cmd_taken = rst_n && in_if.valid && in_if.ready;
    res_taken = rst_n && out_if.valid && out_if.ready;
    if (cmd_taken) begin
      apply_command(ssus_pkg::op_e'(in_if.opcode), in_if.key, in_if.count);
    end
    if (res_taken) begin
      if (predicted_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: status %0d value %0d last %0b",
                   out_if.status, out_if.entry_value, out_if.is_last);
      end else begin
        want = predicted_q.pop_front();
        if (out_if.status !== want.status || out_if.entry_value !== want.value ||
            out_if.is_last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: status %0d/%0d value %0d/%0d last %0b/%0b (exp/got)",
                     want.status, out_if.status, want.value, out_if.entry_value,
                     want.last, out_if.is_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_sorted_unique_set_store_core: errors");
      $finish;
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // command driver
  always @(negedge clk) begin
    bit   nxt_valid;
    cmd_t c;
    if (rst_n) begin
      nxt_valid = in_if.valid && !cmd_taken;
      if (!nxt_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (cmd_q.size() > 0) begin
          c = cmd_q.pop_front();
          in_if.opcode <= c.op;
          in_if.key    <= c.key;
          in_if.count  <= c.count;
          nxt_valid = 1'b1;
          send_wait = calm ? 0 : $urandom_range(0, 19);
        end
      end
      in_if.valid <= nxt_valid;
    end
  end

  // result ready
  always @(negedge clk) begin
    bit nxt_ready;
    if (rst_n) begin
      if (res_taken) recv_wait = calm ? 0 : $urandom_range(0, 19);
      nxt_ready = 1'b0;
      if (hold_left == 0) begin
        if (recv_wait > 0) recv_wait--;
        else nxt_ready = 1'b1;
      end
      out_if.ready <= nxt_ready;
    end
  end

  task automatic push_cmd(input ssus_pkg::op_e op,
                          input logic signed [ssus_pkg::KEY_W-1:0] key,
                          input logic [ssus_pkg::COUNT_W-1:0] count);
    cmd_t c;
    c.op    = op;
    c.key   = key;
    c.count = count;
    cmd_q.push_back(c);
  endtask

  function automatic logic signed [ssus_pkg::KEY_W-1:0] rand_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return key_pool[$urandom_range(0, POOL_N-1)];
    if (r < 85) return $urandom;
    return $signed($urandom_range(0, 16)) - 8;
  endfunction

  task automatic push_random(input int n, input int ins_pct);
    int                           r;
    ssus_pkg::op_e                op;
    logic [ssus_pkg::COUNT_W-1:0] cnt;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) op = ssus_pkg::OP_INSERT;
      else if (r < ins_pct + 25) op = ssus_pkg::OP_REMOVE;
      else if (r < 97) op = ssus_pkg::OP_READ;
      else op = ssus_pkg::OP_CLEAR;
      cnt = $urandom_range(0, 1) ? ssus_pkg::COUNT_W'($urandom_range(0, 63))
                                 : ssus_pkg::COUNT_W'($urandom_range(0, 8));
      push_cmd(op, (op == ssus_pkg::OP_INSERT || op == ssus_pkg::OP_REMOVE) ?
               rand_key() : $urandom, cnt);
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (cmd_q.size() != 0 || in_if.valid || predicted_q.size() != 0);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.opcode = ssus_pkg::OP_INSERT;
    in_if.key    = '0;
    in_if.count  = '0;
    out_if.ready = 1'b0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    hold_ack     = 1'b0;
    hold_left    = 0;
    send_wait    = 0;
    recv_wait    = 0;
    errors       = 0;
    cycles       = 0;
    set_size     = 0;
    cmd_taken    = 1'b0;
    res_taken    = 1'b0;
    for (int i = 0; i < CAP; i++) set_val[i] = '0;
    key_pool[0] = 32'sh7fffffff;
    key_pool[1] = 32'sh80000000;
    key_pool[2] = 0;
    key_pool[3] = -1;
    for (int i = 4; i < POOL_N; i++) key_pool[i] = $urandom;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    push_cmd(ssus_pkg::OP_READ,   $urandom, 6'd5);
    push_cmd(ssus_pkg::OP_REMOVE, 5, 6'd0);
    push_cmd(ssus_pkg::OP_INSERT, 32'sh7fffffff, 6'd0);
    push_cmd(ssus_pkg::OP_INSERT, 32'sh80000000, 6'd63);
    push_cmd(ssus_pkg::OP_INSERT, 0, 6'd0);
    push_cmd(ssus_pkg::OP_INSERT, -1, 6'd0);
    push_cmd(ssus_pkg::OP_INSERT, 1, 6'd0);
    push_cmd(ssus_pkg::OP_INSERT, 0, 6'd0);
    push_cmd(ssus_pkg::OP_REMOVE, 7, 6'd0);
    push_cmd(ssus_pkg::OP_READ,   $urandom, 6'd0);
    push_cmd(ssus_pkg::OP_READ,   $urandom, 6'd63);
    push_cmd(ssus_pkg::OP_READ,   $urandom, 6'd2);
    push_cmd(ssus_pkg::OP_REMOVE, -1, 6'd0);
    push_cmd(ssus_pkg::OP_REMOVE, 32'sh80000000, 6'd0);
    push_cmd(ssus_pkg::OP_READ,   $urandom, 6'd32);
    push_cmd(ssus_pkg::OP_CLEAR,  $urandom, 6'd17);
    push_cmd(ssus_pkg::OP_READ,   $urandom, 6'd1);
    push_cmd(ssus_pkg::OP_INSERT, 32'sh80000000, 6'd0);
    push_cmd(ssus_pkg::OP_READ,   $urandom, 6'd1);
    push_cmd(ssus_pkg::OP_CLEAR,  $urandom, 6'd0);
    wait_drained();

    // fill past capacity, then mixed traffic
    for (int i = 4; i < 44; i++)
      push_cmd(ssus_pkg::OP_INSERT, key_pool[i], ssus_pkg::COUNT_W'($urandom));
    push_cmd(ssus_pkg::OP_READ, $urandom, 6'd40);
    push_random(80, 45);
    wait_drained();

    // receiver stalls while the sender streams
    calm     = 1'b1;
    hold_req = ~hold_req;
    push_random(60, 50);
    wait_drained();

    for (int k = 0; k < 4; k++) begin
      calm = k[0];
      push_random(20, 40);
    end
    wait_drained();

    repeat (3 * CAP) @(posedge clk);
    if (errors == 0 && predicted_q.size() == 0) begin
      $display("tb_sorted_unique_set_store_core: clean");
    end else begin
      $display("tb_sorted_unique_set_store_core: errors");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ssus_pkg.sv
hw/rtl/ssus_if.sv
hw/rtl/ssus_cell.sv
hw/rtl/sorted_unique_set_store_core.sv
test/tb_sorted_unique_set_store_core.sv
